[rtl/core/upcc_pkg.sv]
package upcc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NUM_RES = 3;

  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_USCR  = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    HELD_NONE      = 3'b001,
    HELD_SLASH     = 3'b010,
    HELD_SLASH_DOT = 3'b100
  } held_t;

  function automatic logic allowed_char(input byte_t c);
    logic ok;
    begin
      ok = (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) ||
           (c inside {[8'h30:8'h39]}) ||
           (c inside {CH_SLASH, CH_DASH, CH_USCR, CH_DOT, CH_TILDE});
      return ok;
    end
  endfunction

endpackage

[rtl/core/uri_path_check_and_clean.sv]
// Channel  Direction  Payload                                  Handshake
// in_      input      in_ch, in_is_last                        in_valid / in_stall
// out_     output     out_char, out_end_of_path, out_path_ok   out_valid / out_stall
//
// Each request is taken straight into a three-entry result register; one
// result leaves per cycle while out_stall is low. A request giving one result
// or none is taken every cycle while out_stall is low; one giving more holds
// the input off while the result register drains. Synchronous active-low reset
// clears the pattern history, the held bytes and the result count. in_stall
// rises while earlier results remain that will not all be gone at the next edge.
module uri_path_check_and_clean
  import upcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_ch,
  input  logic              in_is_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_char,
  output logic              out_end_of_path,
  output logic              out_path_ok
);

  byte_t      hist0_r, hist1_r, hist2_r;
  byte_t      hist0_nxt, hist1_nxt, hist2_nxt;
  held_t      held_r, held_nxt, held_upd;
  logic       first_r, first_nxt;
  logic       rej_r, rej_nxt, rej_upd;

  byte_t      buf_char_r [NUM_RES];
  logic       buf_eop_r  [NUM_RES];
  logic       buf_ok_r   [NUM_RES];
  byte_t      buf_char_nxt [NUM_RES];
  logic       buf_eop_nxt  [NUM_RES];
  logic       buf_ok_nxt   [NUM_RES];
  logic [1:0] cnt_r, cnt_nxt;

  byte_t      em_char [NUM_RES];
  logic [1:0] em_n;

  logic       out_fire, in_fire;

  assign out_valid       = (cnt_r != 2'd0);
  assign out_fire        = out_valid && !out_stall;
  assign in_stall        = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_fire));
  assign in_fire         = in_valid && !in_stall;
  assign out_char        = buf_char_r[0];
  assign out_end_of_path = buf_eop_r[0];
  assign out_path_ok     = buf_ok_r[0];

  // pattern checks and dot-segment collapse for the incoming byte
  always_comb begin
    rej_upd = rej_r;
    if (hist0_r == CH_SLASH && in_ch == CH_SLASH) rej_upd = 1'b1;
    if (hist2_r == CH_SLASH && hist1_r == CH_DOT && hist0_r == CH_DOT &&
        in_ch == CH_SLASH) rej_upd = 1'b1;
    if (!first_r && !allowed_char(in_ch)) rej_upd = 1'b1;

    for (int i = 0; i < NUM_RES; i++) em_char[i] = CH_SLASH;
    em_n     = 2'd0;
    held_upd = HELD_NONE;

    case (held_r)
      HELD_SLASH: begin
        if (in_ch == CH_DOT) begin
          held_upd = HELD_SLASH_DOT;
        end else if (in_ch == CH_SLASH) begin
          em_n     = 2'd1;
          held_upd = HELD_SLASH;
        end else begin
          em_char[1] = in_ch;
          em_n       = 2'd2;
        end
      end
      HELD_SLASH_DOT: begin
        if (in_ch == CH_SLASH) begin
          held_upd = HELD_SLASH;
        end else begin
          em_char[1] = CH_DOT;
          em_char[2] = in_ch;
          em_n       = 2'd3;
        end
      end
      default: begin
        if (in_ch == CH_SLASH) begin
          held_upd = HELD_SLASH;
        end else begin
          em_char[0] = in_ch;
          em_n       = 2'd1;
        end
      end
    endcase

    // flush only follows zero or one emitted byte
    if (in_is_last && held_upd != HELD_NONE) begin
      em_char[em_n] = CH_SLASH;
      if (held_upd == HELD_SLASH_DOT) begin
        em_char[em_n + 2'd1] = CH_DOT;
        em_n                 = em_n + 2'd2;
      end else begin
        em_n = em_n + 2'd1;
      end
    end
  end

  always_comb begin
    hist0_nxt = hist0_r;
    hist1_nxt = hist1_r;
    hist2_nxt = hist2_r;
    held_nxt  = held_r;
    first_nxt = first_r;
    rej_nxt   = rej_r;
    cnt_nxt   = cnt_r;
    for (int i = 0; i < NUM_RES; i++) begin
      buf_char_nxt[i] = buf_char_r[i];
      buf_eop_nxt[i]  = buf_eop_r[i];
      buf_ok_nxt[i]   = buf_ok_r[i];
    end

    if (out_fire) begin
      for (int i = 0; i < NUM_RES - 1; i++) begin
        buf_char_nxt[i] = buf_char_r[i+1];
        buf_eop_nxt[i]  = buf_eop_r[i+1];
        buf_ok_nxt[i]   = buf_ok_r[i+1];
      end
      cnt_nxt = cnt_r - 2'd1;
    end

    if (in_fire) begin
      for (int i = 0; i < NUM_RES; i++) begin
        buf_char_nxt[i] = em_char[i];
        buf_eop_nxt[i]  = in_is_last && (em_n == 2'(i + 1));
        buf_ok_nxt[i]   = in_is_last && (em_n == 2'(i + 1)) && !rej_upd;
      end
      cnt_nxt = em_n;
      if (in_is_last) begin
        hist0_nxt = '0;
        hist1_nxt = '0;
        hist2_nxt = '0;
        held_nxt  = HELD_NONE;
        first_nxt = 1'b1;
        rej_nxt   = 1'b0;
      end else begin
        hist0_nxt = in_ch;
        hist1_nxt = hist0_r;
        hist2_nxt = hist1_r;
        held_nxt  = held_upd;
        first_nxt = 1'b0;
        rej_nxt   = rej_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
      hist2_r <= '0;
      held_r  <= HELD_NONE;
      first_r <= 1'b1;
      rej_r   <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      hist0_r <= hist0_nxt;
      hist1_r <= hist1_nxt;
      hist2_r <= hist2_nxt;
      held_r  <= held_nxt;
      first_r <= first_nxt;
      rej_r   <= rej_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_RES; i++) begin
      buf_char_r[i] <= buf_char_nxt[i];
      buf_eop_r[i]  <= buf_eop_nxt[i];
      buf_ok_r[i]   <= buf_ok_nxt[i];
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import upcc_pkg::*;

  typedef struct packed {
    byte_t ch;
    logic  eop;
    logic  ok;
  } clean_byte_t;

  logic  clk        = 1'b0;
  logic  rst_n      = 1'b0;
  logic  in_valid   = 1'b0;
  logic  in_stall;
  byte_t in_ch      = '0;
  logic  in_is_last = 1'b0;
  logic  out_valid;
  logic  out_stall  = 1'b0;
  byte_t out_char;
  logic  out_end_of_path;
  logic  out_path_ok;

  clean_byte_t expected_bytes[$];
  clean_byte_t want;

  // predictor state
  byte_t raw_seen[3];
  held_t held_run;
  logic  next_is_first;
  logic  path_bad;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req_cycles = 0;
  int hold_left = 0;
  int errors = 0;
  int n_bytes = 0;
  int n_paths = 0;
  int n_rejected = 0;
  int n_checked = 0;

  uri_path_check_and_clean i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_end_of_path (out_end_of_path),
    .out_path_ok     (out_path_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic path_char_legal(input byte_t c);
    if (c >= 8'h61 && c <= 8'h7A) return 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) return 1'b1;
    if (c >= 8'h30 && c <= 8'h39) return 1'b1;
    return (c == CH_SLASH) || (c == CH_DASH) || (c == CH_USCR) ||
           (c == CH_DOT) || (c == CH_TILDE);
  endfunction

  task automatic clear_path_state();
    raw_seen[0]   = '0;
    raw_seen[1]   = '0;
    raw_seen[2]   = '0;
    held_run      = HELD_NONE;
    next_is_first = 1'b1;
    path_bad      = 1'b0;
  endtask

  task automatic add_clean(ref clean_byte_t batch[$], input byte_t c);
    clean_byte_t r;
    r.ch  = c;
    r.eop = 1'b0;
    r.ok  = 1'b0;
    batch.push_back(r);
  endtask

  task automatic clean_path_byte(input byte_t c, input logic last);
    clean_byte_t batch[$];
    if (raw_seen[0] == CH_SLASH && c == CH_SLASH) path_bad = 1'b1;
    if (raw_seen[2] == CH_SLASH && raw_seen[1] == CH_DOT && raw_seen[0] == CH_DOT &&
        c == CH_SLASH) path_bad = 1'b1;
    if (!next_is_first && !path_char_legal(c)) path_bad = 1'b1;
    raw_seen[2]   = raw_seen[1];
    raw_seen[1]   = raw_seen[0];
    raw_seen[0]   = c;
    next_is_first = 1'b0;

    case (held_run)
      HELD_SLASH: begin
        if (c == CH_DOT) begin
          held_run = HELD_SLASH_DOT;
        end else if (c == CH_SLASH) begin
          add_clean(batch, CH_SLASH);
        end else begin
          add_clean(batch, CH_SLASH);
          add_clean(batch, c);
          held_run = HELD_NONE;
        end
      end
      HELD_SLASH_DOT: begin
        if (c == CH_SLASH) begin
          held_run = HELD_SLASH;
        end else begin
          add_clean(batch, CH_SLASH);
          add_clean(batch, CH_DOT);
          add_clean(batch, c);
          held_run = HELD_NONE;
        end
      end
      default: begin
        if (c == CH_SLASH) begin
          held_run = HELD_SLASH;
        end else begin
          add_clean(batch, c);
          held_run = HELD_NONE;
        end
      end
    endcase

    if (last) begin
      if (held_run == HELD_SLASH || held_run == HELD_SLASH_DOT) add_clean(batch, CH_SLASH);
      if (held_run == HELD_SLASH_DOT) add_clean(batch, CH_DOT);
      if (batch.size() > 0) begin
        batch[batch.size()-1].eop = 1'b1;
        batch[batch.size()-1].ok  = !path_bad;
      end
      n_paths++;
      if (path_bad) n_rejected++;
      clear_path_state();
    end
    foreach (batch[i]) expected_bytes.push_back(batch[i]);
  endtask

  // every offered request is accepted in order, so predict on offer
  task automatic send_byte(input byte_t c, input logic last);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    clean_path_byte(c, last);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_ch      <= c;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
  endtask

  task automatic send_path(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]), i == s.len() - 1);
  endtask

  function automatic byte_t pick_path_byte();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 30) return CH_SLASH;
    if (r < 55) return CH_DOT;
    if (r < 65) begin
      k = $urandom_range(0, 2);
      return (k == 0) ? CH_DASH : (k == 1) ? CH_USCR : CH_TILDE;
    end
    if (r < 88) begin
      k = $urandom_range(0, 61);
      if (k < 26) return byte_t'(8'h61 + k);
      if (k < 52) return byte_t'(8'h41 + k - 26);
      return byte_t'(8'h30 + k - 52);
    end
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic test_directed();
    send_path("/");
    send_path("/./x");
    send_path("/../");
    send_path("//");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_path("/.");
    send_path("~-_");
    send_path("/././");
  endtask

  task automatic test_random_paths(input int n_target);
    int sent;
    int len;
    sent = 0;
    while (sent < n_target) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_byte(pick_path_byte(), i == len - 1);
      sent += len;
    end
  endtask

  // long receiver hold-off while the sender keeps offering, so in_stall rises
  task automatic test_backpressure();
    int saved_tx;
    saved_tx        = tx_idle_pct;
    tx_idle_pct     = 0;
    hold_req_cycles = 300;
    test_random_paths(30);
    tx_idle_pct     = saved_tx;
  endtask

  always @(posedge clk) begin
    if (hold_req_cycles > 0) begin
      hold_left       = hold_req_cycles;
      hold_req_cycles = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_char %0h end %0b ok %0b",
               out_char, out_end_of_path, out_path_ok);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        n_checked++;
        if (out_char !== want.ch) begin
          $error("out_char expected %0h actual %0h", want.ch, out_char);
          errors++;
        end
        if (out_end_of_path !== want.eop) begin
          $error("out_end_of_path expected %0b actual %0b", want.eop, out_end_of_path);
          errors++;
        end
        if (out_path_ok !== want.ok) begin
          $error("out_path_ok expected %0b actual %0b", want.ok, out_path_ok);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("timeout");
    $display("testbench failed");
    $finish;
  end

  initial begin
    clear_path_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 23;
    rx_idle_pct = 77;
    test_directed();
    test_random_paths(100);

    tx_idle_pct = 77;
    rx_idle_pct = 23;
    test_random_paths(100);
    test_backpressure();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_paths(100);

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d paths (%0d rejected), checked %0d cleaned bytes,",
             n_bytes, n_paths, n_rejected, n_checked);
    $display("under mixed idling on both sides and one long receiver hold-off.");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/upcc_pkg.sv
rtl/core/uri_path_check_and_clean.sv
tb/testbench.sv
